// ===== src/max_pool_2d_stream_assert.svh =====
// ----------------------------------------------------------------
// max pool 2d stream assertion macros
// concurrent property helpers used by the top level
// ----------------------------------------------------------------
`ifndef MAX_POOL_2D_STREAM_ASSERT_SVH
`define MAX_POOL_2D_STREAM_ASSERT_SVH

// same-cycle implication
`define MPS_ASSERT_IMPL(lbl, clk_i, rstn_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
		else $error("max pool assertion failed");

// next-cycle implication
`define MPS_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
		else $error("max pool assertion failed");

`endif

// ===== src/mps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------
// mps_pkg
// shared types and constants of the max pooling stream block
// ----------------------------------------------------------------
package mps_pkg;

	localparam int MAX_KERNEL_DEF  = 4;
	localparam int MAX_WIDTH_DEF   = 256;
	localparam int SAMPLE_BITS_DEF = 16;

	localparam int DIM_BITS      = 9;
	localparam int KS_BITS       = 3;
	localparam int IDX_BITS      = 8;
	localparam int HEIGHT_LIMIT  = 256;
	localparam int STRIDE_LIMIT  = 4;
	localparam int CFG_ADDR_BITS = 4;
	localparam int CFG_DATA_BITS = 32;

	// register indexes
	localparam logic [1:0] REG_HEIGHT = 2'd0;
	localparam logic [1:0] REG_WIDTH  = 2'd1;
	localparam logic [1:0] REG_KERNEL = 2'd2;
	localparam logic [1:0] REG_STRIDE = 2'd3;

	localparam logic [DIM_BITS-1:0] RST_HEIGHT = 9'd16;
	localparam logic [DIM_BITS-1:0] RST_WIDTH  = 9'd16;
	localparam logic [KS_BITS-1:0]  RST_KERNEL = 3'd2;
	localparam logic [KS_BITS-1:0]  RST_STRIDE = 3'd2;

	typedef struct packed {
		logic [DIM_BITS-1:0] height;
		logic [DIM_BITS-1:0] width;
		logic [KS_BITS-1:0]  kernel;
		logic [KS_BITS-1:0]  stride;
	} cfg_t;

	// position and flag of one pooled result
	typedef struct packed {
		logic                last;
		logic [IDX_BITS-1:0] out_col;
		logic [IDX_BITS-1:0] out_row;
	} res_tag_t;

endpackage

// ===== src/mps_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------
// mps_cfg_regs
// apb register file for plane geometry, kernel and stride
// ----------------------------------------------------------------
module mps_cfg_regs (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [mps_pkg::CFG_ADDR_BITS-1:0]   paddr,
	input  logic [mps_pkg::CFG_DATA_BITS-1:0]   pwdata,
	output logic [mps_pkg::CFG_DATA_BITS-1:0]   prdata,
	output logic                                 pready,
	output mps_pkg::cfg_t                        cfg,
	output logic                                 restart
);

	mps_pkg::cfg_t cfg_q;
	logic          wr_en;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign restart = wr_en;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.height <= mps_pkg::RST_HEIGHT;
			cfg_q.width  <= mps_pkg::RST_WIDTH;
			cfg_q.kernel <= mps_pkg::RST_KERNEL;
			cfg_q.stride <= mps_pkg::RST_STRIDE;
		end else if (wr_en) begin
			case (paddr[3:2])
				mps_pkg::REG_HEIGHT: cfg_q.height <= pwdata[mps_pkg::DIM_BITS-1:0];
				mps_pkg::REG_WIDTH:  cfg_q.width  <= pwdata[mps_pkg::DIM_BITS-1:0];
				mps_pkg::REG_KERNEL: cfg_q.kernel <= pwdata[mps_pkg::KS_BITS-1:0];
				mps_pkg::REG_STRIDE: cfg_q.stride <= pwdata[mps_pkg::KS_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			mps_pkg::REG_HEIGHT: prdata = mps_pkg::CFG_DATA_BITS'(cfg_q.height);
			mps_pkg::REG_WIDTH:  prdata = mps_pkg::CFG_DATA_BITS'(cfg_q.width);
			mps_pkg::REG_KERNEL: prdata = mps_pkg::CFG_DATA_BITS'(cfg_q.kernel);
			mps_pkg::REG_STRIDE: prdata = mps_pkg::CFG_DATA_BITS'(cfg_q.stride);
			default:             prdata = '0;
		endcase
	end

endmodule

// ===== src/mps_line_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------
// mps_line_store
// synchronous line memory, one write and one registered read port
// ----------------------------------------------------------------
module mps_line_store #(
	parameter  int MAX_KERNEL  = mps_pkg::MAX_KERNEL_DEF,
	parameter  int MAX_WIDTH   = mps_pkg::MAX_WIDTH_DEF,
	parameter  int SAMPLE_BITS = mps_pkg::SAMPLE_BITS_DEF,
	localparam int WIDTH_LIMIT = (MAX_WIDTH < 256) ? MAX_WIDTH : 256,
	localparam int COL_BITS    = $clog2(WIDTH_LIMIT),
	localparam int SLOT_BITS   = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1
) (
	input  logic                              clk,
	input  logic                              we,
	input  logic [SLOT_BITS-1:0]              wslot,
	input  logic [COL_BITS-1:0]               wcol,
	input  logic [SAMPLE_BITS-1:0]            wdata,
	input  logic                              re,
	input  logic [SLOT_BITS-1:0]              rslot,
	input  logic [COL_BITS-1:0]               rcol,
	output logic [SAMPLE_BITS-1:0]            rdata
);

	localparam int DEPTH       = MAX_KERNEL * MAX_WIDTH;
	localparam int ADDR_BITS   = $clog2(DEPTH);

	logic [SAMPLE_BITS-1:0] mem [DEPTH];
	logic [ADDR_BITS-1:0]   waddr;
	logic [ADDR_BITS-1:0]   raddr;

	// row slot selects a line, column selects the sample within it
	assign waddr = ADDR_BITS'(32'(wslot) * MAX_WIDTH + 32'(wcol));
	assign raddr = ADDR_BITS'(32'(rslot) * MAX_WIDTH + 32'(rcol));

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== src/mps_pos_track.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------
// mps_pos_track
// raster position, stride phase and pooled index counters
// ----------------------------------------------------------------
module mps_pos_track #(
	parameter  int MAX_KERNEL  = mps_pkg::MAX_KERNEL_DEF,
	parameter  int MAX_WIDTH   = mps_pkg::MAX_WIDTH_DEF,
	localparam int WIDTH_LIMIT = (MAX_WIDTH < 256) ? MAX_WIDTH : 256,
	localparam int COL_BITS    = $clog2(WIDTH_LIMIT),
	localparam int SLOT_BITS   = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1,
	localparam int K_BITS      = $clog2(MAX_KERNEL + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mps_pkg::cfg_t        cfg,
	input  logic                 restart,
	input  logic                 advance,
	output logic                 emit,
	output logic [SLOT_BITS-1:0] cur_slot,
	output logic [COL_BITS-1:0]  cur_col,
	output logic [K_BITS-1:0]    k_eff,
	output logic [SLOT_BITS-1:0] start_slot,
	output logic [COL_BITS-1:0]  start_col,
	output mps_pkg::res_tag_t    tag
);

	localparam int DB          = mps_pkg::DIM_BITS;
	localparam int IB          = mps_pkg::IDX_BITS;

	logic [IB-1:0]        in_row_q;
	logic [COL_BITS-1:0]  in_col_q;
	logic [SLOT_BITS-1:0] row_slot_q;
	logic [1:0]           row_phase_q;
	logic [1:0]           col_phase_q;
	logic [IB-1:0]        pooled_row_q;
	logic [IB-1:0]        pooled_col_q;

	logic [DB-1:0]        h_c;
	logic [DB-1:0]        w_c;
	logic [K_BITS-1:0]    k_c;
	logic [2:0]           s_c;
	logic                 row_active;
	logic                 col_active;
	logic                 row_end;
	logic                 plane_end;
	logic                 last_win;
	logic [1:0]           rp_next;
	logic [1:0]           cp_next;
	logic [SLOT_BITS-1:0] slot_next;

	always_comb begin
		if (cfg.height == '0) begin
			h_c = DB'(1);
		end else if (32'(cfg.height) > mps_pkg::HEIGHT_LIMIT) begin
			h_c = DB'(mps_pkg::HEIGHT_LIMIT);
		end else begin
			h_c = cfg.height;
		end

		if (cfg.width == '0) begin
			w_c = DB'(1);
		end else if (32'(cfg.width) > WIDTH_LIMIT) begin
			w_c = DB'(WIDTH_LIMIT);
		end else begin
			w_c = cfg.width;
		end

		if (cfg.kernel == '0) begin
			k_c = K_BITS'(1);
		end else if (32'(cfg.kernel) > MAX_KERNEL) begin
			k_c = K_BITS'(MAX_KERNEL);
		end else begin
			k_c = K_BITS'(cfg.kernel);
		end

		if (cfg.stride == '0) begin
			s_c = 3'd1;
		end else if (32'(cfg.stride) > mps_pkg::STRIDE_LIMIT) begin
			s_c = 3'(mps_pkg::STRIDE_LIMIT);
		end else begin
			s_c = cfg.stride;
		end
	end

	assign row_active = (DB'(in_row_q) + DB'(1)) >= DB'(k_c);
	assign col_active = (DB'(in_col_q) + DB'(1)) >= DB'(k_c);
	assign row_end    = (DB'(in_col_q) + DB'(1)) >= w_c;
	assign plane_end  = (DB'(in_row_q) + DB'(1)) >= h_c;

	// a window is the last of its plane when the next stride step leaves the plane in both rows and columns
	assign last_win = ((10'(in_row_q) + 10'(s_c)) >= 10'(h_c))
		&& ((10'(in_col_q) + 10'(s_c)) >= 10'(w_c));

	assign rp_next   = ((3'(row_phase_q) + 3'd1) == s_c) ? 2'd0 : row_phase_q + 2'd1;
	assign cp_next   = ((3'(col_phase_q) + 3'd1) == s_c) ? 2'd0 : col_phase_q + 2'd1;
	assign slot_next = (32'(row_slot_q) == MAX_KERNEL - 1) ? '0 : row_slot_q + SLOT_BITS'(1);

	assign emit = row_active && col_active && (row_phase_q == 2'd0) && (col_phase_q == 2'd0);

	assign cur_slot = row_slot_q;
	assign cur_col  = in_col_q;
	assign k_eff    = k_c;

	always_comb begin
		if (32'(row_slot_q) + 1 >= 32'(k_c)) begin
			start_slot = SLOT_BITS'(32'(row_slot_q) + 1 - 32'(k_c));
		end else begin
			start_slot = SLOT_BITS'(32'(row_slot_q) + MAX_KERNEL + 1 - 32'(k_c));
		end
	end

	assign start_col = COL_BITS'(32'(in_col_q) + 1 - 32'(k_c));

	assign tag.last    = last_win;
	assign tag.out_col = pooled_col_q;
	assign tag.out_row = pooled_row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q     <= '0;
			in_col_q     <= '0;
			row_slot_q   <= '0;
			row_phase_q  <= '0;
			col_phase_q  <= '0;
			pooled_row_q <= '0;
			pooled_col_q <= '0;
		end else if (restart) begin
			in_row_q     <= '0;
			in_col_q     <= '0;
			row_slot_q   <= '0;
			row_phase_q  <= '0;
			col_phase_q  <= '0;
			pooled_row_q <= '0;
			pooled_col_q <= '0;
		end else if (advance) begin
			if (emit) begin
				pooled_col_q <= pooled_col_q + IB'(1);
			end
			if (col_active) begin
				col_phase_q <= cp_next;
			end
			if (row_end) begin
				in_col_q     <= '0;
				col_phase_q  <= '0;
				pooled_col_q <= '0;
				if (row_active) begin
					if ((row_phase_q == 2'd0) && (w_c >= DB'(k_c))) begin
						pooled_row_q <= pooled_row_q + IB'(1);
					end
					row_phase_q <= rp_next;
				end
				if (plane_end) begin
					in_row_q     <= '0;
					row_slot_q   <= '0;
					row_phase_q  <= '0;
					pooled_row_q <= '0;
				end else begin
					in_row_q   <= in_row_q + IB'(1);
					row_slot_q <= slot_next;
				end
			end else begin
				in_col_q <= in_col_q + COL_BITS'(1);
			end
		end
	end

endmodule

// ===== src/mps_window_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------
// mps_window_scan
// walks one k by k window through the line store and keeps the max
// ----------------------------------------------------------------
module mps_window_scan #(
	parameter  int MAX_KERNEL  = mps_pkg::MAX_KERNEL_DEF,
	parameter  int MAX_WIDTH   = mps_pkg::MAX_WIDTH_DEF,
	parameter  int SAMPLE_BITS = mps_pkg::SAMPLE_BITS_DEF,
	localparam int WIDTH_LIMIT = (MAX_WIDTH < 256) ? MAX_WIDTH : 256,
	localparam int COL_BITS    = $clog2(WIDTH_LIMIT),
	localparam int SLOT_BITS   = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1,
	localparam int K_BITS      = $clog2(MAX_KERNEL + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [K_BITS-1:0]       k_in,
	input  logic [SLOT_BITS-1:0]    slot_in,
	input  logic [COL_BITS-1:0]     col_in,
	input  logic [COL_BITS-1:0]     col_end_in,
	input  mps_pkg::res_tag_t       tag_in,
	output logic                    busy,
	output logic                    rd_en,
	output logic [SLOT_BITS-1:0]    rd_slot,
	output logic [COL_BITS-1:0]     rd_col,
	input  logic [SAMPLE_BITS-1:0]  rd_data,
	output logic                    res_valid,
	input  logic                    res_ready,
	output logic [SAMPLE_BITS-1:0]  res_best,
	output mps_pkg::res_tag_t       res_tag
);

	typedef enum logic [1:0] {
		SC_IDLE,
		SC_SCAN,
		SC_DRAIN,
		SC_FIN
	} scan_state_t;

	scan_state_t            state_q;
	logic [SLOT_BITS-1:0]   slot_q;
	logic [COL_BITS-1:0]    col_q;
	logic [COL_BITS-1:0]    col0_q;
	logic [COL_BITS-1:0]    col_end_q;
	logic [K_BITS-1:0]      row_cnt_q;
	logic [K_BITS-1:0]      k_q;
	mps_pkg::res_tag_t      tag_q;
	logic                   have_q;
	logic                   rd_vld_s1;
	logic [SAMPLE_BITS-1:0] best_q;
	logic                   row_done;
	logic                   last_rd;

	assign row_done  = (col_q == col_end_q);
	assign last_rd   = row_done && (row_cnt_q == k_q - K_BITS'(1));
	assign busy      = (state_q != SC_IDLE);
	assign rd_en     = (state_q == SC_SCAN);
	assign rd_slot   = slot_q;
	assign rd_col    = col_q;
	assign res_valid = (state_q == SC_FIN);
	assign res_best  = best_q;
	assign res_tag   = tag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= SC_IDLE;
			slot_q    <= '0;
			col_q     <= '0;
			col0_q    <= '0;
			col_end_q <= '0;
			row_cnt_q <= '0;
			k_q       <= '0;
			tag_q     <= '0;
			have_q    <= 1'b0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == SC_SCAN);
			if (rd_vld_s1) begin
				have_q <= 1'b1;
			end
			case (state_q)
				SC_IDLE: begin
					if (start) begin
						slot_q    <= slot_in;
						col_q     <= col_in;
						col0_q    <= col_in;
						col_end_q <= col_end_in;
						row_cnt_q <= '0;
						k_q       <= k_in;
						tag_q     <= tag_in;
						have_q    <= 1'b0;
						state_q   <= SC_SCAN;
					end
				end
				SC_SCAN: begin
					if (row_done) begin
						col_q     <= col0_q;
						row_cnt_q <= row_cnt_q + K_BITS'(1);
						if (32'(slot_q) == MAX_KERNEL - 1) begin
							slot_q <= '0;
						end else begin
							slot_q <= slot_q + SLOT_BITS'(1);
						end
					end else begin
						col_q <= col_q + COL_BITS'(1);
					end
					if (last_rd) begin
						state_q <= SC_DRAIN;
					end
				end
				SC_DRAIN: begin
					state_q <= SC_FIN;
				end
				SC_FIN: begin
					if (res_ready) begin
						state_q <= SC_IDLE;
					end
				end
				default: begin
					state_q <= SC_IDLE;
				end
			endcase
		end
	end

	// running signed maximum, first sample of the window loads directly
	always_ff @(posedge clk) begin
		if (rd_vld_s1 && (!have_q || ($signed(rd_data) > $signed(best_q)))) begin
			best_q <= rd_data;
		end
	end

endmodule

// ===== src/max_pool_2d_stream.sv =====
// a sample that closes no window leaves s_tready high, the next beat may follow at once
// a sample that closes a k by k window holds s_tready low until the scan is back in idle:
// one line store read per window sample, then read drain, then result handoff, which waits
// while the output register is full; the single read port of the line store sets the reads
// reset: arst_n clears counters, scan state and output valid, registers take their defaults
// line store contents are not cleared, every window only reads rows written in the current plane
`timescale 1ns / 1ps
// ----------------------------------------------------------------
// max_pool_2d_stream
// streaming 2-d max pooling over raster-order feature planes
// ----------------------------------------------------------------
`include "max_pool_2d_stream_assert.svh"

module max_pool_2d_stream #(
	parameter  int MAX_KERNEL  = mps_pkg::MAX_KERNEL_DEF,
	parameter  int MAX_WIDTH   = mps_pkg::MAX_WIDTH_DEF,
	parameter  int SAMPLE_BITS = mps_pkg::SAMPLE_BITS_DEF,
	localparam int IN_W        = ((SAMPLE_BITS + 7) / 8) * 8,
	localparam int OUT_W       = ((SAMPLE_BITS + 2 * mps_pkg::IDX_BITS + 7) / 8) * 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// input sample stream
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [IN_W-1:0]                    s_tdata,   // sample
	// pooled result stream
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [OUT_W-1:0]                   m_tdata,   // pooled, out_row, out_col
	output logic                               m_tlast,   // last_of_plane
	// configuration port
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [mps_pkg::CFG_ADDR_BITS-1:0]  paddr,
	input  logic [mps_pkg::CFG_DATA_BITS-1:0]  pwdata,
	output logic [mps_pkg::CFG_DATA_BITS-1:0]  prdata,
	output logic                               pready
);

	localparam int WIDTH_LIMIT = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
	localparam int COL_BITS    = $clog2(WIDTH_LIMIT);
	localparam int SLOT_BITS   = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
	localparam int K_BITS      = $clog2(MAX_KERNEL + 1);

	mps_pkg::cfg_t          cfg;
	logic                   restart;

	logic                   in_accept;
	logic                   win_emit;
	logic [SLOT_BITS-1:0]   cur_slot;
	logic [COL_BITS-1:0]    cur_col;
	logic [K_BITS-1:0]      k_eff;
	logic [SLOT_BITS-1:0]   start_slot;
	logic [COL_BITS-1:0]    start_col;
	mps_pkg::res_tag_t      win_tag;

	logic                   scan_busy;
	logic                   store_re;
	logic [SLOT_BITS-1:0]   rd_slot;
	logic [COL_BITS-1:0]    rd_col;
	logic [SAMPLE_BITS-1:0] rd_data;
	logic                   res_valid;
	logic                   res_ready;
	logic [SAMPLE_BITS-1:0] res_best;
	mps_pkg::res_tag_t      res_tag;

	logic                   out_valid_q;
	logic [SAMPLE_BITS-1:0] out_pooled_q;
	mps_pkg::res_tag_t      out_tag_q;

	// register file, any write restarts the current plane
	mps_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg),
		.restart (restart)
	);

	// the scan owns the store read port, so input is held off while a window is walked
	assign s_tready  = !scan_busy;
	assign in_accept = s_tvalid && s_tready;

	mps_pos_track #(
		.MAX_KERNEL (MAX_KERNEL),
		.MAX_WIDTH  (MAX_WIDTH)
	) u_pos (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.restart    (restart),
		.advance    (in_accept),
		.emit       (win_emit),
		.cur_slot   (cur_slot),
		.cur_col    (cur_col),
		.k_eff      (k_eff),
		.start_slot (start_slot),
		.start_col  (start_col),
		.tag        (win_tag)
	);

	// every accepted beat lands in the line store, the window read starts the cycle after
	mps_line_store #(
		.MAX_KERNEL  (MAX_KERNEL),
		.MAX_WIDTH   (MAX_WIDTH),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_store (
		.clk   (clk),
		.we    (in_accept),
		.wslot (cur_slot),
		.wcol  (cur_col),
		.wdata (s_tdata[SAMPLE_BITS-1:0]),
		.re    (store_re),
		.rslot (rd_slot),
		.rcol  (rd_col),
		.rdata (rd_data)
	);

	mps_window_scan #(
		.MAX_KERNEL  (MAX_KERNEL),
		.MAX_WIDTH   (MAX_WIDTH),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (in_accept && win_emit),
		.k_in       (k_eff),
		.slot_in    (start_slot),
		.col_in     (start_col),
		.col_end_in (cur_col),
		.tag_in     (win_tag),
		.busy       (scan_busy),
		.rd_en      (store_re),
		.rd_slot    (rd_slot),
		.rd_col     (rd_col),
		.rd_data    (rd_data),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_best   (res_best),
		.res_tag    (res_tag)
	);

	// output register parts the scan from the downstream stall
	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_pooled_q <= res_best;
			out_tag_q    <= res_tag;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_W'({out_tag_q.out_col, out_tag_q.out_row, out_pooled_q});
	assign m_tlast  = out_tag_q.last;

	// a window-closing beat must stall the input right away
	`MPS_ASSERT_NEXT(a_emit_blocks_input, clk, arst_n, in_accept && win_emit, !s_tready)
	// store write and window read never share a cycle
	`MPS_ASSERT_IMPL(a_store_port_free, clk, arst_n, in_accept, !store_re)
	// a finished window waits in the scan until the output register takes it
	`MPS_ASSERT_NEXT(a_result_held, clk, arst_n, res_valid && !res_ready, res_valid)
	// a handed-over result shows up on the master side
	`MPS_ASSERT_NEXT(a_result_lands, clk, arst_n, res_valid && res_ready, m_tvalid)

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------
// testbench
// self-checking bench for the streaming 2-d max pooling block: a
// scoreboard class predicts every pooled beat from the accepted input
// beats and the register writes, and checks the result stream in order
// ----------------------------------------------------------------
import mps_pkg::*;

typedef struct packed {
	logic [SAMPLE_BITS_DEF-1:0] pooled;
	res_tag_t                   tag;
} pool_result_t;

class pool_scoreboard;
	logic [SAMPLE_BITS_DEF-1:0] row_buf [MAX_KERNEL_DEF*MAX_WIDTH_DEF];
	int unsigned  in_row, in_col, row_phase, col_phase, pooled_row, pooled_col;
	cfg_t         cfg;
	pool_result_t window_max_q [$];
	int           errors, checked;

	function new();
		cfg.height = RST_HEIGHT;
		cfg.width  = RST_WIDTH;
		cfg.kernel = RST_KERNEL;
		cfg.stride = RST_STRIDE;
		errors = 0;
		checked = 0;
		clear_position();
	endfunction

	function void clear_position();
		in_row = 0;
		in_col = 0;
		row_phase = 0;
		col_phase = 0;
		pooled_row = 0;
		pooled_col = 0;
	endfunction

	function int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function int unsigned plane_beats();
		return clampu(cfg.height, 1, HEIGHT_LIMIT) * clampu(cfg.width, 1, MAX_WIDTH_DEF);
	endfunction

	function int pending();
		return window_max_q.size();
	endfunction

	// any write restarts the plane, the line buffer keeps its contents
	function void write_reg(logic [1:0] idx, logic [CFG_DATA_BITS-1:0] word);
		case (idx)
			REG_HEIGHT: cfg.height = word[DIM_BITS-1:0];
			REG_WIDTH:  cfg.width  = word[DIM_BITS-1:0];
			REG_KERNEL: cfg.kernel = word[KS_BITS-1:0];
			REG_STRIDE: cfg.stride = word[KS_BITS-1:0];
			default: ;
		endcase
		clear_position();
	endfunction

	function void note_pixel(logic [SAMPLE_BITS_DEF-1:0] pix);
		int unsigned h, w, k, s, h_out, w_out, r, c;
		bit row_act, col_act;
		logic signed [SAMPLE_BITS_DEF-1:0] best, cur;
		pool_result_t res;
		h = clampu(cfg.height, 1, HEIGHT_LIMIT);
		w = clampu(cfg.width, 1, MAX_WIDTH_DEF);
		k = clampu(cfg.kernel, 1, MAX_KERNEL_DEF);
		s = clampu(cfg.stride, 1, STRIDE_LIMIT);
		row_act = (in_row + 1 >= k);
		col_act = (in_col + 1 >= k);
		if (in_row >= h)
			in_row = 0;
		if (in_col >= w)
			in_col = 0;
		row_buf[(in_row % MAX_KERNEL_DEF) * MAX_WIDTH_DEF + in_col] = pix;

		if (row_act && col_act && row_phase == 0 && col_phase == 0) begin
			best = {1'b1, {(SAMPLE_BITS_DEF-1){1'b0}}};
			for (r = in_row + 1 - k; r <= in_row; r++) begin
				for (c = in_col + 1 - k; c <= in_col; c++) begin
					cur = $signed(row_buf[(r % MAX_KERNEL_DEF) * MAX_WIDTH_DEF + c]);
					if (cur > best)
						best = cur;
				end
			end
			h_out = (h - k) / s + 1;
			w_out = (w - k) / s + 1;
			res.pooled = best;
			res.tag.out_row = pooled_row[IDX_BITS-1:0];
			res.tag.out_col = pooled_col[IDX_BITS-1:0];
			res.tag.last = (pooled_row == h_out - 1) && (pooled_col == w_out - 1);
			window_max_q.push_back(res);
			pooled_col = (pooled_col + 1) & 8'hff;
		end

		if (col_act)
			col_phase = (col_phase + 1 == s) ? 0 : col_phase + 1;

		if (in_col + 1 >= w) begin
			in_col = 0;
			col_phase = 0;
			pooled_col = 0;
			if (row_act) begin
				if (row_phase == 0 && w >= k)
					pooled_row = (pooled_row + 1) & 8'hff;
				row_phase = (row_phase + 1 == s) ? 0 : row_phase + 1;
			end
			if (in_row + 1 >= h)
				clear_position();
			else
				in_row++;
		end else begin
			in_col++;
		end
	endfunction

	task report(string msg);
		errors++;
		$display("mismatch: %s", msg);
	endtask

	task check_result(logic [SAMPLE_BITS_DEF-1:0] pooled, res_tag_t tag);
		pool_result_t want;
		if (window_max_q.size() == 0) begin
			report($sformatf("pooled %h row %0d col %0d with nothing outstanding",
				pooled, tag.out_row, tag.out_col));
			return;
		end
		want = window_max_q.pop_front();
		checked++;
		if (pooled !== want.pooled)
			report($sformatf("pooled %h, want %h", pooled, want.pooled));
		if (tag.out_row !== want.tag.out_row)
			report($sformatf("out_row %0d, want %0d", tag.out_row, want.tag.out_row));
		if (tag.out_col !== want.tag.out_col)
			report($sformatf("out_col %0d, want %0d", tag.out_col, want.tag.out_col));
		if (tag.last !== want.tag.last)
			report($sformatf("last_of_plane %0b, want %0b at row %0d col %0d",
				tag.last, want.tag.last, want.tag.out_row, want.tag.out_col));
	endtask
endclass

module testbench;

	localparam int HALF_PERIOD  = 5;
	localparam int SETTLE       = 24;      // above the longest window read
	localparam int RANDOM_BEATS = 130;
	localparam int HOLD_CYCLES  = 300;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     s_tvalid;
	logic                     s_tready;
	logic [15:0]              s_tdata;    // sample
	logic                     m_tvalid;
	logic                     m_tready;
	logic [31:0]              m_tdata;    // pooled [15:0], out_row [23:16], out_col [31:24]
	logic                     m_tlast;    // last_of_plane
	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic [CFG_ADDR_BITS-1:0] paddr;
	logic [CFG_DATA_BITS-1:0] pwdata;
	logic [CFG_DATA_BITS-1:0] prdata;
	logic                     pready;

	pool_scoreboard sb;

	int send_idle_pct;
	int recv_idle_pct;
	int hold_left = 0;
	int beats_sent = 0;
	int settings_used = 0;

	// corner values of the sample range, two 2x2 windows on a 2x4 plane
	logic [15:0] corner_pixels [8] = '{16'h8000, 16'h8000, 16'h7fff, 16'hffff,
		16'h8000, 16'h8000, 16'h0000, 16'h0001};

	always #(HALF_PERIOD) clk = ~clk;

	max_pool_2d_stream u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// mostly random, with a good share of range corners and tiny values for ties
	function automatic logic [15:0] pick_pixel();
		case ($urandom_range(7))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'($urandom_range(3));
			default: return 16'($urandom);
		endcase
	endfunction

	// one input beat; random gaps before it, valid held until the handshake
	task automatic send_pixel(input logic [15:0] pix);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= pix;
		do @(posedge clk); while (!s_tready);
		sb.note_pixel(pix);
		beats_sent++;
	endtask

	// sender stops until every pooled beat is back, then lets the block settle
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// setup cycle, access cycle, bus released on the next falling edge
	task automatic write_reg(input logic [1:0] idx, input logic [DIM_BITS-1:0] value);
		logic [CFG_DATA_BITS-1:0] word;
		word = ($urandom << DIM_BITS) | value;   // junk above the field width
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= word;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.write_reg(idx, word);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic set_plane(input int height, input int width, input int kernel,
		input int stride);
		drain();
		write_reg(REG_HEIGHT, DIM_BITS'(height));
		write_reg(REG_WIDTH, DIM_BITS'(width));
		write_reg(REG_KERNEL, DIM_BITS'(kernel));
		write_reg(REG_STRIDE, DIM_BITS'(stride));
		settings_used++;
	endtask

	// result side: random or held-off tready, every accepted beat goes to the scoreboard
	initial begin
		res_tag_t seen_tag;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				seen_tag.out_row = m_tdata[23:16];
				seen_tag.out_col = m_tdata[31:24];
				seen_tag.last    = m_tlast;
				sb.check_result(m_tdata[15:0], seen_tag);
			end
		end
	end

	// safety net far above the slowest passing run
	initial begin
		#(5_000_000);
		$display("timeout: pooled stream stopped making progress");
		$display("status: fail");
		$finish;
	end

	initial begin
		int random_sent;
		int burst;
		int phase;
		int i;
		logic [DIM_BITS-1:0] dim;
		sb = new();
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		send_idle_pct = 7;
		recv_idle_pct = 53;
		random_sent = 0;
		phase = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: range corners through two windows
		set_plane(2, 4, 2, 2);
		foreach (corner_pixels[j])
			send_pixel(corner_pixels[j]);

		// directed: kernel taller than the plane and as wide as it, nothing comes out
		set_plane(2, 3, 3, 1);
		repeat (6) send_pixel(pick_pixel());

		// directed: all registers zero act as a 1x1 plane with unit kernel and stride
		set_plane(0, 0, 0, 0);
		repeat (3) send_pixel(pick_pixel());

		// random settings; bursts are mostly whole planes, some cut off mid-plane
		while (random_sent < RANDOM_BEATS) begin
			if (random_sent >= 2 * RANDOM_BEATS / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end else if (random_sent >= RANDOM_BEATS / 3) begin
				send_idle_pct = 53;
				recv_idle_pct = 7;
			end
			if (phase == 0) begin
				// result side holds off while the sender keeps offering beats
				set_plane(4, 4, 1, 1);
				hold_left = HOLD_CYCLES;
				burst = 16;
			end else begin
				drain();
				for (i = 0; i < 4; i++) begin
					if (phase == 1 || $urandom_range(3) != 0) begin
						case (i)
							0, 1: begin
								case ($urandom_range(9))
									0: dim = '0;
									1: dim = DIM_BITS'($urandom_range(257, 511));
									default: dim = DIM_BITS'($urandom_range(1, 8));
								endcase
								write_reg((i == 0) ? REG_HEIGHT : REG_WIDTH, dim);
							end
							2: write_reg(REG_KERNEL, DIM_BITS'($urandom_range(7)));
							default: write_reg(REG_STRIDE, DIM_BITS'($urandom_range(7)));
						endcase
					end
				end
				settings_used++;
				if (sb.plane_beats() <= 32 && $urandom_range(3) != 0)
					burst = sb.plane_beats() * $urandom_range(1, 2);
				else
					burst = $urandom_range(1, 24);
			end
			repeat (burst) send_pixel(pick_pixel());
			random_sent += burst;
			phase++;
		end

		// tallest plane, height above range acts as 256, pooled rows up to 255
		set_plane(300, 1, 1, 1);
		repeat (HEIGHT_LIMIT) send_pixel(pick_pixel());

		drain();

		$display("summary: %0d input beats over %0d register settings, %0d pooled beats checked",
			beats_sent, settings_used, sb.checked);
		$display("summary: corner values, clamped registers, kernels past the plane, %s",
			"cut-off planes and long output back-pressure");
		if (sb.errors == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches", sb.errors);
			$display("status: fail");
		end
		$finish;
	end

endmodule
